// File: sv/prrs_pkg.sv
// Shared types, constants and request codes of the priority round-robin scheduler.
package prrs_pkg;

    localparam int TOP_PRIORITY_DEF = 15;
    localparam int MAX_ENTRIES_DEF  = 64;
    localparam int QUEUE_DEPTH      = 2;

    localparam logic [2:0] REQ_ENQUEUE = 3'd0;
    localparam logic [2:0] REQ_PREEMPT = 3'd1;
    localparam logic [2:0] REQ_EXIT    = 3'd2;
    localparam logic [2:0] REQ_REQUEUE = 3'd3;
    localparam logic [2:0] REQ_REMOVE  = 3'd4;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_EMPTY     = 3'd1;
    localparam logic [2:0] ST_NOT_FOUND = 3'd2;
    localparam logic [2:0] ST_FULL      = 3'd3;
    localparam logic [2:0] ST_BAD_LEVEL = 3'd4;
    localparam logic [2:0] ST_NO_PREV   = 3'd5;

    typedef struct packed {
        logic [2:0]  req_type;
        logic [15:0] pid;
        logic [3:0]  priority_req;
    } request_t;

    typedef struct packed {
        logic [2:0]  status;
        logic        switched;
        logic [15:0] chosen_pid;
        logic [15:0] run_pid;
        logic [3:0]  run_priority;
    } result_t;

    // Classified request handed from the front end to the back end.
    typedef struct packed {
        logic [2:0]  op;
        logic [15:0] pid;
        logic [3:0]  level;
        logic        bad_level;
    } command_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_POP_RD,
        S_POP_WAIT,
        S_POP_DONE,
        S_PUSH,
        S_PUSH_RD,
        S_PUSH_WAIT,
        S_PUSH_DONE,
        S_RM_LEVEL,
        S_RM_RD,
        S_RM_WAIT,
        S_RM_CHECK,
        S_RESULT
    } exec_state_t;

endpackage

// File: sv/prrs_front.sv
// Front end: accept requests, classify them and queue them for the back end.
module prrs_front #(
    parameter int TOP_PRIORITY = prrs_pkg::TOP_PRIORITY_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  prrs_pkg::request_t request,
    output logic               busy,
    input  logic               pop,
    output logic               cmd_valid,
    output prrs_pkg::command_t cmd
);
    import prrs_pkg::*;

    localparam int PW = $clog2(QUEUE_DEPTH);

    command_t       fifo_reg [QUEUE_DEPTH];
    logic [PW-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [PW:0]    count_reg;
    logic           push;
    command_t       cls;

    // Hold at most one request while the back end runs the one before it.
    assign busy      = (count_reg != '0) || pop;
    assign push      = start && !busy;
    assign cmd_valid = (count_reg != '0);
    assign cmd       = fifo_reg[rd_ptr_reg];

    always_comb
    begin
        cls.op        = request.req_type;
        cls.pid       = request.pid;
        cls.level     = request.priority_req;
        cls.bad_level = ({2'b0, request.priority_req} > 6'(TOP_PRIORITY));
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_reg[wr_ptr_reg] <= cls;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_reg + (push ? 1'b1 : 1'b0) - (pop ? 1'b1 : 1'b0);
        end
    end

endmodule

// File: sv/prrs_back.sv
// Back end: linked queue store and the sequencer that carries out each request.
module prrs_back #(
    parameter int TOP_PRIORITY = prrs_pkg::TOP_PRIORITY_DEF,
    parameter int MAX_ENTRIES  = prrs_pkg::MAX_ENTRIES_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cmd_valid,
    input  prrs_pkg::command_t cmd,
    output logic               pop,
    input  logic               cfg_valid,
    input  logic [15:0]        cfg_data,
    output logic               res_valid,
    output prrs_pkg::result_t  res
);
    import prrs_pkg::*;

    localparam int LEVELS = TOP_PRIORITY + 1;
    localparam int EW     = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CW     = $clog2(MAX_ENTRIES + 1);
    localparam int LW     = $clog2(LEVELS);

    // Entry store: link and pid share one read address; each has its own write port.
    logic [EW-1:0] link_mem [MAX_ENTRIES];
    logic [15:0]   pid_mem  [MAX_ENTRIES];
    logic [EW-1:0] rd_link_reg;
    logic [15:0]   rd_pid_reg;
    logic          mem_rd;
    logic [EW-1:0] mem_raddr;
    logic          link_we, data_we;
    logic [EW-1:0] link_waddr, link_wdata, data_waddr;
    logic [15:0]   data_wpid;

    // Free-list links start out chained; a fill count hands out fresh entries.
    logic [CW-1:0] fresh_reg, fresh_next;

    logic [EW-1:0] head_reg [LEVELS];
    logic [EW-1:0] tail_reg [LEVELS];
    logic [LEVELS-1:0] nonempty_reg, nonempty_next;
    logic [EW-1:0] free_head_reg, free_head_next;
    logic [CW-1:0] free_count_reg, free_count_next;

    logic [15:0]   cur_pid_reg, cur_pid_next, prev_pid_reg, prev_pid_next;
    logic [LW-1:0] cur_level_reg, cur_level_next, prev_level_reg, prev_level_next;
    logic          prev_valid_reg, prev_valid_next, started_reg, started_next;

    exec_state_t   state_reg, state_next;
    command_t      op_reg, op_next;
    logic [LW-1:0] lv_reg, lv_next;
    logic [EW-1:0] ent_reg, ent_next, before_reg, before_next;
    logic          has_before_reg, has_before_next;
    logic [EW-1:0] new_ent_reg, new_ent_next;
    logic [2:0]    status_reg, status_next;
    logic          sw_reg, sw_next;
    logic [15:0]   chosen_reg, chosen_next;

    logic          head_we, tail_we;
    logic [LW-1:0] ht_lv;
    logic [EW-1:0] head_wdata, tail_wdata;

    logic [LW-1:0] top_lv;
    logic          top_found;
    logic [LW-1:0] low_lv;
    logic          level_ok;

    // Priority encoder over the level mask.
    always_comb
    begin
        top_lv    = '0;
        top_found = 1'b0;
        low_lv    = (op_reg.op == REQ_PREEMPT) ? cur_level_reg : '0;
        for (int i = 0; i < LEVELS; i++)
        begin
            if (nonempty_reg[i] && (LW'(i) >= low_lv))
            begin
                top_lv    = LW'(i);
                top_found = 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (link_we)
        begin
            link_mem[link_waddr] <= link_wdata;
        end
        if (data_we)
        begin
            pid_mem[data_waddr] <= data_wpid;
        end
        if (mem_rd)
        begin
            rd_link_reg <= link_mem[mem_raddr];
            rd_pid_reg  <= pid_mem[mem_raddr];
        end
    end

    // Entry links at or above the fill count read as the reset chain i+1.
    function automatic logic [EW-1:0] link_of(input logic [EW-1:0] e,
                                              input logic [EW-1:0] raw,
                                              input logic [CW-1:0] fresh);
        logic [EW-1:0] r;
        if ({1'b0, e} >= fresh)
        begin
            r = (32'(e) == MAX_ENTRIES - 1) ? '0 : e + 1'b1;
        end
        else
        begin
            r = raw;
        end
        return r;
    endfunction

    logic [EW-1:0] rd_link;
    assign rd_link = link_of(ent_reg, rd_link_reg, fresh_reg);
    assign level_ok = 1'b1;

    always_ff @(posedge clk)
    begin
        if (head_we)
        begin
            head_reg[ht_lv] <= head_wdata;
        end
        if (tail_we)
        begin
            tail_reg[ht_lv] <= tail_wdata;
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        op_next         = op_reg;
        lv_next         = lv_reg;
        ent_next        = ent_reg;
        before_next     = before_reg;
        has_before_next = has_before_reg;
        new_ent_next    = new_ent_reg;
        status_next     = status_reg;
        sw_next         = sw_reg;
        chosen_next     = chosen_reg;
        nonempty_next   = nonempty_reg;
        free_head_next  = free_head_reg;
        free_count_next = free_count_reg;
        fresh_next      = fresh_reg;
        cur_pid_next    = cur_pid_reg;
        cur_level_next  = cur_level_reg;
        prev_pid_next   = prev_pid_reg;
        prev_level_next = prev_level_reg;
        prev_valid_next = prev_valid_reg;
        started_next    = started_reg;
        pop        = 1'b0;
        res_valid  = 1'b0;
        mem_rd     = 1'b0;
        mem_raddr  = ent_reg;
        link_we    = 1'b0;
        link_waddr = '0;
        link_wdata = '0;
        data_we    = 1'b0;
        data_waddr = '0;
        data_wpid  = '0;
        head_we    = 1'b0;
        tail_we    = 1'b0;
        ht_lv      = lv_reg;
        head_wdata = '0;
        tail_wdata = '0;

        res.status       = status_reg;
        res.switched     = sw_reg;
        res.chosen_pid   = chosen_reg;
        res.run_pid      = cur_pid_reg;
        res.run_priority = 4'(cur_level_reg);

        if (cfg_valid)
        begin
            if (!started_reg)
            begin
                cur_pid_next   = cfg_data;
                cur_level_next = '0;
            end
        end

        case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    pop            = 1'b1;
                    op_next        = cmd;
                    status_next    = ST_OK;
                    sw_next        = 1'b0;
                    chosen_next    = '0;
                    state_next     = S_RESULT;
                    case (cmd.op)
                        REQ_ENQUEUE:
                        begin
                            if (cmd.bad_level)
                            begin
                                status_next = ST_BAD_LEVEL;
                            end
                            else
                            begin
                                lv_next    = cmd.level[LW-1:0];
                                state_next = S_PUSH;
                            end
                        end
                        REQ_PREEMPT, REQ_EXIT:
                        begin
                            state_next = S_POP_RD;
                        end
                        REQ_REQUEUE:
                        begin
                            if (!prev_valid_reg)
                            begin
                                status_next = ST_NO_PREV;
                            end
                            else
                            begin
                                lv_next        = prev_level_reg;
                                op_next.pid    = prev_pid_reg;
                                state_next     = S_PUSH;
                            end
                        end
                        REQ_REMOVE:
                        begin
                            lv_next    = '0;
                            state_next = S_RM_LEVEL;
                        end
                        default:
                        begin
                            state_next = S_RESULT;
                        end
                    endcase
                end
            end

            // Pick: find the level, read its head entry.
            S_POP_RD:
            begin
                if (!top_found)
                begin
                    status_next = ST_EMPTY;
                    state_next  = S_RESULT;
                end
                else
                begin
                    lv_next    = top_lv;
                    ent_next   = head_reg[top_lv];
                    mem_raddr  = head_reg[top_lv];
                    mem_rd     = 1'b1;
                    state_next = S_POP_WAIT;
                end
            end

            S_POP_WAIT:
            begin
                state_next = S_POP_DONE;
            end

            S_POP_DONE:
            begin
                ht_lv = lv_reg;
                if (tail_reg[lv_reg] == ent_reg)
                begin
                    nonempty_next[lv_reg] = 1'b0;
                    head_we    = 1'b1;
                    tail_we    = 1'b1;
                end
                else
                begin
                    head_we    = 1'b1;
                    head_wdata = rd_link;
                end
                link_we         = 1'b1;
                link_waddr      = ent_reg;
                link_wdata      = free_head_reg;
                free_head_next  = ent_reg;
                free_count_next = free_count_reg + 1'b1;
                if ({1'b0, ent_reg} >= fresh_reg)
                begin
                    fresh_next = CW'({1'b0, ent_reg}) + 1'b1;
                end
                chosen_next = rd_pid_reg;
                sw_next     = 1'b1;
                if (op_reg.op == REQ_PREEMPT)
                begin
                    prev_pid_next   = cur_pid_reg;
                    prev_level_next = cur_level_reg;
                    prev_valid_next = 1'b1;
                end
                else
                begin
                    prev_valid_next = 1'b0;
                end
                cur_pid_next   = rd_pid_reg;
                cur_level_next = lv_reg;
                started_next   = 1'b1;
                state_next     = S_RESULT;
            end

            // Push: take the free head and read its link.
            S_PUSH:
            begin
                if (free_count_reg == '0)
                begin
                    status_next = ST_FULL;
                    state_next  = S_RESULT;
                end
                else
                begin
                    ent_next   = free_head_reg;
                    mem_raddr  = free_head_reg;
                    mem_rd     = 1'b1;
                    state_next = S_PUSH_WAIT;
                end
            end

            S_PUSH_WAIT:
            begin
                state_next = S_PUSH_DONE;
            end

            S_PUSH_DONE:
            begin
                free_head_next  = rd_link;
                free_count_next = free_count_reg - 1'b1;
                if ({1'b0, ent_reg} >= fresh_reg)
                begin
                    fresh_next = CW'({1'b0, ent_reg}) + 1'b1;
                end
                data_we    = 1'b1;
                data_waddr = ent_reg;
                data_wpid  = op_reg.pid;
                ht_lv      = lv_reg;
                tail_we    = 1'b1;
                tail_wdata = ent_reg;
                if (nonempty_reg[lv_reg])
                begin
                    link_we    = 1'b1;
                    link_waddr = tail_reg[lv_reg];
                    link_wdata = ent_reg;
                end
                else
                begin
                    head_we    = 1'b1;
                    head_wdata = ent_reg;
                end
                nonempty_next[lv_reg] = 1'b1;
                if (op_reg.op == REQ_REQUEUE)
                begin
                    prev_valid_next = 1'b0;
                end
                state_next = S_RESULT;
            end

            // Remove: walk levels upward, each from its head.
            S_RM_LEVEL:
            begin
                if (nonempty_reg[lv_reg])
                begin
                    ent_next        = head_reg[lv_reg];
                    has_before_next = 1'b0;
                    state_next      = S_RM_RD;
                end
                else if (32'(lv_reg) == TOP_PRIORITY)
                begin
                    status_next = ST_NOT_FOUND;
                    state_next  = S_RESULT;
                end
                else
                begin
                    lv_next = lv_reg + 1'b1;
                end
            end

            S_RM_RD:
            begin
                mem_raddr  = ent_reg;
                mem_rd     = 1'b1;
                state_next = S_RM_WAIT;
            end

            S_RM_WAIT:
            begin
                state_next = S_RM_CHECK;
            end

            S_RM_CHECK:
            begin
                ht_lv = lv_reg;
                if (rd_pid_reg == op_reg.pid)
                begin
                    if (!has_before_reg)
                    begin
                        if (tail_reg[lv_reg] == ent_reg)
                        begin
                            nonempty_next[lv_reg] = 1'b0;
                            head_we = 1'b1;
                            tail_we = 1'b1;
                        end
                        else
                        begin
                            head_we    = 1'b1;
                            head_wdata = rd_link;
                        end
                        // Free the entry: its link is rewritten below.
                    end
                    else
                    begin
                        if (tail_reg[lv_reg] == ent_reg)
                        begin
                            tail_we    = 1'b1;
                            tail_wdata = before_reg;
                        end
                    end
                    // Relink the predecessor first, the freed entry next cycle.
                    if (has_before_reg)
                    begin
                        link_we    = 1'b1;
                        link_waddr = before_reg;
                        link_wdata = rd_link;
                        new_ent_next = ent_reg;
                        state_next   = S_PUSH_RD;
                    end
                    else
                    begin
                        link_we         = 1'b1;
                        link_waddr      = ent_reg;
                        link_wdata      = free_head_reg;
                        free_head_next  = ent_reg;
                        free_count_next = free_count_reg + 1'b1;
                        state_next      = S_RESULT;
                    end
                end
                else if (tail_reg[lv_reg] == ent_reg)
                begin
                    if (32'(lv_reg) == TOP_PRIORITY)
                    begin
                        status_next = ST_NOT_FOUND;
                        state_next  = S_RESULT;
                    end
                    else
                    begin
                        lv_next    = lv_reg + 1'b1;
                        state_next = S_RM_LEVEL;
                    end
                end
                else
                begin
                    before_next     = ent_reg;
                    has_before_next = 1'b1;
                    ent_next        = rd_link;
                    state_next      = S_RM_RD;
                end
            end

            // Second write of a mid-list removal: free the unlinked entry.
            S_PUSH_RD:
            begin
                link_we         = 1'b1;
                link_waddr      = new_ent_reg;
                link_wdata      = free_head_reg;
                free_head_next  = new_ent_reg;
                free_count_next = free_count_reg + 1'b1;
                state_next      = S_RESULT;
            end

            S_RESULT:
            begin
                res_valid  = level_ok;
                state_next = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Removed entries were all pushed, so they lie below the fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            nonempty_reg   <= '0;
            free_head_reg  <= '0;
            free_count_reg <= CW'(MAX_ENTRIES);
            fresh_reg      <= '0;
            cur_pid_reg    <= '0;
            cur_level_reg  <= '0;
            prev_pid_reg   <= '0;
            prev_level_reg <= '0;
            prev_valid_reg <= 1'b0;
            started_reg    <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            nonempty_reg   <= nonempty_next;
            free_head_reg  <= free_head_next;
            free_count_reg <= free_count_next;
            fresh_reg      <= fresh_next;
            cur_pid_reg    <= cur_pid_next;
            cur_level_reg  <= cur_level_next;
            prev_pid_reg   <= prev_pid_next;
            prev_level_reg <= prev_level_next;
            prev_valid_reg <= prev_valid_next;
            started_reg    <= started_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        lv_reg         <= lv_next;
        ent_reg        <= ent_next;
        before_reg     <= before_next;
        has_before_reg <= has_before_next;
        new_ent_reg    <= new_ent_next;
        status_reg     <= status_next;
        sw_reg         <= sw_next;
        chosen_reg     <= chosen_next;
    end

endmodule

// File: sv/priority_round_robin_scheduler.sv
// Top level of the multilevel priority round-robin scheduler.
//
//  channel   handshake              payload
//  request   start / busy           request  (req_type, pid, priority_req)
//  result    done strobe, 1 cycle   result   (status, switched, chosen_pid, ...)
//  config    cfg_valid / cfg_ready  cfg_data (initial_pid)
//
// Enqueue, requeue and pick pass through the request queue, the registered entry read and
// update, and the result state before done. Rejected requests go straight to the result
// state; a full store or an empty pick stops after its first check. Remove by pid adds a
// step per level scanned, a read per entry visited and an extra write to free a mid-list entry.
// Reset clears all queues at once; the free list is rebuilt lazily by a fill count.
// One more request can wait in the queue; done pulses once per request, never stalled.
module priority_round_robin_scheduler #(
    parameter int TOP_PRIORITY = prrs_pkg::TOP_PRIORITY_DEF,
    parameter int MAX_ENTRIES  = prrs_pkg::MAX_ENTRIES_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  prrs_pkg::request_t request,
    output logic               done,
    output prrs_pkg::result_t  result,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [15:0]        cfg_data
);
    import prrs_pkg::*;

    logic     pop;
    logic     cmd_valid;
    command_t cmd;

    // Configuration is always taken; it only loads the running pid before the first switch.
    assign cfg_ready = 1'b1;

    prrs_front #(.TOP_PRIORITY(TOP_PRIORITY)) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .request   (request),
        .busy      (busy),
        .pop       (pop),
        .cmd_valid (cmd_valid),
        .cmd       (cmd)
    );

    prrs_back #(.TOP_PRIORITY(TOP_PRIORITY), .MAX_ENTRIES(MAX_ENTRIES)) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .pop       (pop),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .res_valid (done),
        .res       (result)
    );

endmodule

// File: sv/prrs_checker.sv
// Port-level checker for the scheduler, bound to the top level.
module prrs_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               start,
    input logic               busy,
    input logic               done,
    input prrs_pkg::result_t  result
);
    import prrs_pkg::*;

    a_no_accept_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted request did not raise busy");

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("done held for more than one cycle");

    a_chosen_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !result.switched) |-> (result.chosen_pid == '0))
        else $error("chosen pid without switch");

    a_switch_runs_chosen: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.switched) |-> (result.run_pid == result.chosen_pid
                                       && result.status == ST_OK))
        else $error("switch does not run chosen pid");

endmodule

bind priority_round_robin_scheduler prrs_checker u_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .result (result)
);

// File: bench/tb.sv
// Self-checking testbench for the priority round-robin scheduler.
`timescale 1ns / 1ps

module tb;
    import prrs_pkg::*;

    localparam int NUM_LEVELS  = TOP_PRIORITY_DEF + 1;
    localparam int POOL_SIZE   = MAX_ENTRIES_DEF;
    localparam int DRAIN_WAIT  = 2000;

    logic     clk;
    logic     rst_n;
    logic     start;
    logic     busy;
    request_t request;
    logic     done;
    result_t  result;
    logic     cfg_valid;
    logic     cfg_ready;
    logic [15:0] cfg_data;

    priority_round_robin_scheduler DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .request   (request),
        .done      (done),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Scheduler state as predicted by the testbench.
    logic [15:0] boot_pid;
    logic [15:0] run_pid_q;
    logic [3:0]  run_level_q;
    logic [15:0] prev_pid_q;
    logic [3:0]  prev_level_q;
    logic        prev_valid_q;
    logic [5:0]  next_link [POOL_SIZE];
    logic [15:0] slot_pid [POOL_SIZE];
    logic [5:0]  level_head [NUM_LEVELS];
    logic [5:0]  level_tail [NUM_LEVELS];
    logic [NUM_LEVELS-1:0] level_busy;
    logic [5:0]  free_top;
    int          free_slots;
    logic        has_switched;

    request_t pending_requests [$];
    result_t  expected_results [$];
    logic     failed;
    logic     pause_sender;
    logic     calm_phase;
    logic     cfg_phase;

    task automatic reset_model();
        run_pid_q    = 16'd0;
        run_level_q  = 4'd0;
        prev_pid_q   = 16'd0;
        prev_level_q = 4'd0;
        prev_valid_q = 1'b0;
        boot_pid     = 16'd0;
        for (int i = 0; i < POOL_SIZE; i++)
        begin
            next_link[i] = 6'((i + 1) % POOL_SIZE);
            slot_pid[i]  = 16'd0;
        end
        for (int i = 0; i < NUM_LEVELS; i++)
        begin
            level_head[i] = 6'd0;
            level_tail[i] = 6'd0;
        end
        level_busy   = '0;
        free_top     = 6'd0;
        free_slots   = POOL_SIZE;
        has_switched = 1'b0;
    endtask

    function automatic logic push_slot(input logic [3:0] lv, input logic [15:0] p);
        logic [5:0] e;
        if (free_slots == 0)
            return 1'b0;
        e = free_top;
        free_top = next_link[e];
        free_slots--;
        slot_pid[e]  = p;
        next_link[e] = 6'd0;
        if (level_busy[lv])
            next_link[level_tail[lv]] = e;
        else
            level_head[lv] = e;
        level_tail[lv] = e;
        level_busy[lv] = 1'b1;
        return 1'b1;
    endfunction

    function automatic void release_slot(input logic [5:0] e);
        next_link[e] = free_top;
        free_top = e;
        free_slots++;
    endfunction

    function automatic logic [15:0] pop_level(input logic [3:0] lv);
        logic [5:0]  e;
        logic [15:0] p;
        e = level_head[lv];
        p = slot_pid[e];
        if (level_tail[lv] == e)
        begin
            level_busy[lv] = 1'b0;
            level_head[lv] = 6'd0;
            level_tail[lv] = 6'd0;
        end
        else
            level_head[lv] = next_link[e];
        release_slot(e);
        return p;
    endfunction

    function automatic logic unlink_pid(input logic [15:0] p);
        logic [5:0] e;
        logic [5:0] prior;
        logic       has_prior;
        for (int lv = 0; lv < NUM_LEVELS; lv++)
        begin
            if (!level_busy[lv])
                continue;
            e = level_head[lv];
            prior = 6'd0;
            has_prior = 1'b0;
            for (int s = 0; s < POOL_SIZE; s++)
            begin
                if (slot_pid[e] == p)
                begin
                    if (!has_prior)
                        void'(pop_level(4'(lv)));
                    else
                    begin
                        next_link[prior] = next_link[e];
                        if (level_tail[lv] == e)
                            level_tail[lv] = prior;
                        release_slot(e);
                    end
                    return 1'b1;
                end
                if (e == level_tail[lv])
                    break;
                prior = e;
                has_prior = 1'b1;
                e = next_link[e];
            end
        end
        return 1'b0;
    endfunction

    // Compute the scheduler's answer to one request and advance the model.
    function automatic result_t schedule_request(input request_t r);
        result_t res;
        int      lv;
        res = '0;
        case (r.req_type)
            REQ_ENQUEUE:
            begin
                if (!push_slot(r.priority_req, r.pid))
                    res.status = ST_FULL;
            end
            REQ_PREEMPT, REQ_EXIT:
            begin
                lv = -1;
                for (int l = NUM_LEVELS - 1; l >= 0; l--)
                begin
                    if (lv < 0 && level_busy[l]
                        && (r.req_type == REQ_EXIT || l >= run_level_q))
                        lv = l;
                end
                if (lv < 0)
                    res.status = ST_EMPTY;
                else
                begin
                    res.chosen_pid = pop_level(4'(lv));
                    if (r.req_type == REQ_PREEMPT)
                    begin
                        prev_pid_q   = run_pid_q;
                        prev_level_q = run_level_q;
                        prev_valid_q = 1'b1;
                    end
                    else
                        prev_valid_q = 1'b0;
                    run_pid_q    = res.chosen_pid;
                    run_level_q  = 4'(lv);
                    res.switched = 1'b1;
                    has_switched = 1'b1;
                end
            end
            REQ_REQUEUE:
            begin
                if (!prev_valid_q)
                    res.status = ST_NO_PREV;
                else if (!push_slot(prev_level_q, prev_pid_q))
                    res.status = ST_FULL;
                else
                    prev_valid_q = 1'b0;
            end
            REQ_REMOVE:
            begin
                if (!unlink_pid(r.pid))
                    res.status = ST_NOT_FOUND;
            end
            default:
            begin
            end
        endcase
        res.run_pid      = run_pid_q;
        res.run_priority = run_level_q;
        return res;
    endfunction

    // Driver: present queued requests, idling at random outside calm stretches.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            start <= 1'b0;
        else
        begin
            if (start && !busy)
                expected_results.push_back(schedule_request(request));
            if ((start && busy) || (!(start && !busy) && start))
                start <= 1'b1;
            else if (pending_requests.size() > 0 && !pause_sender && !cfg_phase
                     && (calm_phase || $urandom_range(99) >= 37))
            begin
                request <= pending_requests.pop_front();
                start   <= 1'b1;
            end
            else
                start <= 1'b0;
        end
    end

    // Monitor: check each result strobe against the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (expected_results.size() == 0)
            begin
                $display("%0t: unexpected result %h", $time, result);
                failed <= 1'b1;
            end
            else
            begin
                result_t want;
                want = expected_results.pop_front();
                if (result.status !== want.status || result.switched !== want.switched
                    || result.chosen_pid !== want.chosen_pid
                    || result.run_pid !== want.run_pid
                    || result.run_priority !== want.run_priority)
                begin
                    $display("%0t: expected %h actual %h", $time, want, result);
                    failed <= 1'b1;
                end
            end
        end
    end

    task automatic queue_request(input logic [2:0] op, input logic [15:0] p,
                                 input logic [3:0] lv);
        request_t r;
        r.req_type     = op;
        r.pid          = p;
        r.priority_req = lv;
        pending_requests.push_back(r);
    endtask

    task automatic wait_drained();
        while (pending_requests.size() > 0 || start || expected_results.size() > 0)
            @(posedge clk);
        repeat (DRAIN_WAIT / 10) @(posedge clk);
    endtask

    // Write the boot pid register; only done while the block is idle.
    task automatic write_boot_pid(input logic [15:0] v);
        cfg_phase = 1'b1;
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        boot_pid = v;
        if (!has_switched)
        begin
            run_pid_q   = v;
            run_level_q = 4'd0;
        end
        cfg_valid <= 1'b0;
        cfg_phase = 1'b0;
    endtask

    // Mostly well-formed traffic: fill levels, pick, requeue, remove known pids.
    task automatic queue_random(input int count);
        logic [2:0] op;
        int k;
        for (int i = 0; i < count; i++)
        begin
            k = $urandom_range(99);
            if (k < 35)       op = REQ_ENQUEUE;
            else if (k < 55)  op = REQ_PREEMPT;
            else if (k < 65)  op = REQ_EXIT;
            else if (k < 78)  op = REQ_REQUEUE;
            else if (k < 96)  op = REQ_REMOVE;
            else              op = 3'($urandom_range(5, 7));
            queue_request(op,
                ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(15)),
                4'($urandom));
        end
    endtask

    initial
    begin
        failed       = 1'b0;
        pause_sender = 1'b0;
        calm_phase   = 1'b0;
        cfg_phase    = 1'b0;
        request      = '0;
        cfg_valid    = 1'b0;
        cfg_data     = 16'd0;
        reset_model();
        rst_n = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_boot_pid(16'hFFFF);
        // Directed: empty picks, no previous, extremes, remove miss and tail.
        queue_request(REQ_PREEMPT, 16'd0, 4'd0);
        queue_request(REQ_EXIT, 16'd0, 4'd0);
        queue_request(REQ_REQUEUE, 16'd0, 4'd0);
        queue_request(REQ_REMOVE, 16'h1234, 4'd0);
        queue_request(REQ_ENQUEUE, 16'hFFFF, 4'd15);
        queue_request(REQ_ENQUEUE, 16'h0000, 4'd0);
        queue_request(REQ_ENQUEUE, 16'hAAAA, 4'd15);
        queue_request(REQ_ENQUEUE, 16'h5555, 4'd15);
        queue_request(REQ_ENQUEUE, 16'hAAAA, 4'd7);
        queue_request(REQ_REMOVE, 16'h5555, 4'd0);
        queue_request(REQ_ENQUEUE, 16'h0101, 4'd15);
        queue_request(REQ_REMOVE, 16'hAAAA, 4'd0);
        queue_request(REQ_REMOVE, 16'h0BAD, 4'd0);
        queue_request(3'd7, 16'hFFFF, 4'd15);
        queue_request(3'd5, 16'd0, 4'd0);
        queue_request(REQ_PREEMPT, 16'd0, 4'd0);
        queue_request(REQ_REQUEUE, 16'd0, 4'd0);
        queue_request(REQ_PREEMPT, 16'd0, 4'd0);
        queue_request(REQ_EXIT, 16'd0, 4'd0);
        queue_request(REQ_EXIT, 16'd0, 4'd0);
        queue_request(REQ_EXIT, 16'd0, 4'd0);
        queue_request(REQ_EXIT, 16'd0, 4'd0);
        wait_drained();
        // Register write after a switch only updates the register.
        write_boot_pid(16'h0000);

        // Fill the pool past capacity to hit the full store path.
        for (int i = 0; i < POOL_SIZE + 2; i++)
            queue_request(REQ_ENQUEUE, 16'($urandom), 4'($urandom));
        queue_request(REQ_PREEMPT, 16'd0, 4'd0);
        queue_request(REQ_ENQUEUE, 16'h7777, 4'd3);
        queue_request(REQ_REQUEUE, 16'd0, 4'd0);
        queue_random(120);
        // Hold the sender until every expected result is back.
        pause_sender = 1'b1;
        while (expected_results.size() > 0 || start)
            @(posedge clk);
        pause_sender = 1'b0;
        calm_phase = 1'b1;
        queue_random(80);
        wait_drained();
        calm_phase = 1'b0;
        write_boot_pid(16'($urandom));
        queue_random(130);
        wait_drained();

        if (!failed)
            $display("priority_round_robin_scheduler: match");
        else
            $display("priority_round_robin_scheduler: mismatch");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("priority_round_robin_scheduler: mismatch");
        $finish;
    end
endmodule

// File: priority_round_robin_scheduler.f
sv/prrs_pkg.sv
sv/prrs_front.sv
sv/prrs_back.sv
sv/priority_round_robin_scheduler.sv
sv/prrs_checker.sv
bench/tb.sv
